// File: src/htf_pkg.sv
// Shared types and constants for the homogeneous point transform.
// Holds the word structs, matrix register layout and pipeline side data.
// No dependencies.
`timescale 1ns / 1ps

package htf_pkg;

  localparam int COORD_W   = 32;
  localparam int SUM_W     = 68;
  localparam int NUM_REGS  = 8;
  localparam int REG_W     = 64;
  localparam int IDX_W     = 3;
  localparam int LANES     = 3;
  localparam int DIV_STEPS = COORD_W;

  localparam logic [REG_W-1:0] REG_RESET [NUM_REGS] = '{
    64'h0000_0000_0001_0000, 64'h0,
    64'h0001_0000_0000_0000, 64'h0,
    64'h0,                   64'h0000_0000_0001_0000,
    64'h0,                   64'h0001_0000_0000_0000
  };

  localparam logic [COORD_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] SAT_NEG = 32'h8000_0000;

  typedef enum logic {
    FUNC_PROJECT = 1'b0,
    FUNC_ROTATE  = 1'b1
  } func_t;

  typedef struct packed {
    logic               func;
    logic signed [31:0] x_in;
    logic signed [31:0] y_in;
    logic signed [31:0] z_in;
  } point_t;

  typedef struct packed {
    logic signed [31:0] x_out;
    logic signed [31:0] y_out;
    logic signed [31:0] z_out;
    logic               w_zero;
    logic               clipped;
  } result_t;

  typedef struct packed {
    logic                             rotate;
    logic                             wz;
    logic [LANES-1:0]                 neg;
    logic [LANES-1:0]                 ovf;
    logic [LANES-1:0][COORD_W-1:0]    rot;
    logic                             rot_clip;
  } side_t;

endpackage

// File: src/htf_dot.sv
// One matrix row: three coordinate products and optional translation, summed exactly.
// Two register stages. Depends on htf_pkg.
`timescale 1ns / 1ps

module htf_dot import htf_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic signed [31:0]       x,
  input  logic signed [31:0]       y,
  input  logic signed [31:0]       z,
  input  logic signed [31:0]       c0,
  input  logic signed [31:0]       c1,
  input  logic signed [31:0]       c2,
  input  logic signed [31:0]       c3,
  input  logic                     with_t,
  output logic signed [SUM_W-1:0]  sum
);

  logic signed [63:0]      p0, p1, p2;
  logic signed [SUM_W-1:0] t;

  always_ff @(posedge clk) begin
    p0 <= c0 * x;
    p1 <= c1 * y;
    p2 <= c2 * z;
    t  <= with_t ? (SUM_W'(c3) <<< FRAC_BITS) : '0;
  end

  always_ff @(posedge clk) begin
    sum <= SUM_W'(p0) + SUM_W'(p1) + SUM_W'(p2) + t;
  end

endmodule

// File: src/htf_div_stage.sv
// One restoring-division step for all three lanes, sharing a divisor.
// Registered outputs. Depends on htf_pkg.
`timescale 1ns / 1ps

module htf_div_stage import htf_pkg::*; (
  input  logic                             clk,
  input  logic [LANES-1:0][SUM_W-1:0]      rem_i,
  input  logic [LANES-1:0][COORD_W-1:0]    sh_i,
  input  logic [SUM_W-1:0]                 d_i,
  output logic [LANES-1:0][SUM_W-1:0]      rem_o,
  output logic [LANES-1:0][COORD_W-1:0]    sh_o,
  output logic [SUM_W-1:0]                 d_o
);

  logic [LANES-1:0][SUM_W-1:0]   rem_next;
  logic [LANES-1:0][COORD_W-1:0] sh_next;

  always_comb begin
    logic [SUM_W:0] t;
    logic [SUM_W:0] diff;
    logic           ge;
    for (int l = 0; l < LANES; l++) begin
      t    = {rem_i[l], sh_i[l][COORD_W-1]};
      diff = t - {1'b0, d_i};
      ge   = t >= {1'b0, d_i};
      rem_next[l] = ge ? diff[SUM_W-1:0] : t[SUM_W-1:0];
      sh_next[l]  = {sh_i[l][COORD_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    rem_o <= rem_next;
    sh_o  <= sh_next;
    d_o   <= d_i;
  end

endmodule

// File: src/homogeneous_point_transform.sv
// Top level of the homogeneous point transform: matrix registers, row sums,
// divide pipeline and output saturation. Depends on htf_pkg, htf_dot, htf_div_stage.
`timescale 1ns / 1ps

// Usage:
//   Command channel: point is taken at a clock edge with start high and busy low.
//   busy is high only during reset; a new word may enter every cycle.
//   Result channel: result is shown for one cycle with done high; it cannot
//   be held off, so there is no stall anywhere in the block.
//   Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data write one
//   of eight 64-bit matrix registers (two Q coefficients, even column low).
//   cfg_ready is always high; write only while no point is in flight.
//   Pipeline from accept to done: 2 product/sum stages, 1 prep stage,
//   32 one-bit divide stages, 1 output stage. Throughput: one point
//   per cycle; the divide runs as a 32-stage restoring pipeline per lane.
//   Reset loads the identity matrix and empties the pipeline.
//   Mode 0: projective divide by w; zero w gives zeros and w_zero.
//   Mode 1: upper 3x3 only, floor shift. Results saturate and set clipped.
module homogeneous_point_transform import htf_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  point_t            point,
  output logic              done,
  output result_t           result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [REG_W-1:0]  cfg_data
);

  localparam int NW  = SUM_W + FRAC_BITS;
  localparam int NHW = NW - COORD_W;
  localparam int LAT = DIV_STEPS + 4;

  logic [REG_W-1:0] mregs [NUM_REGS];
  logic             accept;

  assign busy      = rst;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) mregs[i] <= REG_RESET[i];
    end else if (cfg_valid && cfg_ready) begin
      mregs[cfg_index] <= cfg_data;
    end
  end

  // row sums
  logic v1, v2;
  logic f1, f2;
  logic signed [SUM_W-1:0] s [4];

  for (genvar r = 0; r < 4; r++) begin : g_row
    htf_dot #(.FRAC_BITS(FRAC_BITS)) u_dot (
      .clk    (clk),
      .x      (point.x_in),
      .y      (point.y_in),
      .z      (point.z_in),
      .c0     (mregs[2*r][31:0]),
      .c1     (mregs[2*r][63:32]),
      .c2     (mregs[2*r+1][31:0]),
      .c3     (mregs[2*r+1][63:32]),
      .with_t (point.func == FUNC_PROJECT),
      .sum    (s[r])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    f1 <= point.func;
    f2 <= f1;
  end

  // prep: magnitudes, overflow check, rotate-mode results
  logic [LANES-1:0][SUM_W-1:0]   rem_p;
  logic [LANES-1:0][COORD_W-1:0] sh_p;
  logic [SUM_W-1:0]              d_p;
  side_t                         side_p;
  logic [LANES-1:0][SUM_W-1:0]   rem_next;
  logic [LANES-1:0][COORD_W-1:0] sh_next;
  logic [SUM_W-1:0]              d_next;
  side_t                         side_next;

  always_comb begin
    logic [SUM_W-1:0]        a;
    logic [NW-1:0]           n;
    logic [NHW-1:0]          nh;
    logic signed [SUM_W-1:0] sr;
    logic                    inr;
    d_next = s[3][SUM_W-1] ? SUM_W'(-s[3]) : SUM_W'(s[3]);
    side_next.rotate   = (f2 == FUNC_ROTATE);
    side_next.wz       = (s[3] == '0);
    side_next.rot_clip = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      a  = s[l][SUM_W-1] ? SUM_W'(-s[l]) : SUM_W'(s[l]);
      n  = {a, {FRAC_BITS{1'b0}}};
      nh = n[NW-1:COORD_W];
      side_next.neg[l] = s[l][SUM_W-1] ^ s[3][SUM_W-1];
      side_next.ovf[l] = SUM_W'(nh) >= d_next;
      rem_next[l] = SUM_W'(nh);
      sh_next[l]  = n[COORD_W-1:0];
      sr  = s[l] >>> FRAC_BITS;
      inr = (&sr[SUM_W-1:COORD_W-1]) || !(|sr[SUM_W-1:COORD_W-1]);
      side_next.rot[l] = inr ? sr[COORD_W-1:0] : (sr[SUM_W-1] ? SAT_NEG : SAT_POS);
      if (!inr) side_next.rot_clip = 1'b1;
    end
  end

  logic v_p;

  always_ff @(posedge clk) begin
    if (rst) v_p <= 1'b0;
    else     v_p <= v2;
  end

  always_ff @(posedge clk) begin
    rem_p  <= rem_next;
    sh_p   <= sh_next;
    d_p    <= d_next;
    side_p <= side_next;
  end

  // divide pipeline
  logic [LANES-1:0][SUM_W-1:0]   rem_s [DIV_STEPS+1];
  logic [LANES-1:0][COORD_W-1:0] sh_s  [DIV_STEPS+1];
  logic [SUM_W-1:0]              d_s   [DIV_STEPS+1];
  side_t                         side_s [DIV_STEPS+1];
  logic [DIV_STEPS:0]            v_s;

  assign rem_s[0]  = rem_p;
  assign sh_s[0]   = sh_p;
  assign d_s[0]    = d_p;
  assign side_s[0] = side_p;
  assign v_s[0]    = v_p;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    htf_div_stage u_stage (
      .clk   (clk),
      .rem_i (rem_s[k]),
      .sh_i  (sh_s[k]),
      .d_i   (d_s[k]),
      .rem_o (rem_s[k+1]),
      .sh_o  (sh_s[k+1]),
      .d_o   (d_s[k+1])
    );

    always_ff @(posedge clk) begin
      side_s[k+1] <= side_s[k];
    end

    always_ff @(posedge clk) begin
      if (rst) v_s[k+1] <= 1'b0;
      else     v_s[k+1] <= v_s[k];
    end
  end

  // output saturation
  result_t result_next;
  side_t   sd;

  assign sd = side_s[DIV_STEPS];

  always_comb begin
    logic [LANES-1:0][COORD_W-1:0] val;
    logic [COORD_W-1:0]            q;
    logic                          clip;
    clip = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      q = sh_s[DIV_STEPS][l];
      if (sd.rotate) begin
        val[l] = sd.rot[l];
      end else if (sd.wz) begin
        val[l] = '0;
      end else if (sd.neg[l]) begin
        if (sd.ovf[l] || (q > SAT_NEG)) begin
          val[l] = SAT_NEG;
          clip   = 1'b1;
        end else begin
          val[l] = ~q + 1'b1;
        end
      end else begin
        if (sd.ovf[l] || q[COORD_W-1]) begin
          val[l] = SAT_POS;
          clip   = 1'b1;
        end else begin
          val[l] = q;
        end
      end
    end
    result_next.x_out   = val[0];
    result_next.y_out   = val[1];
    result_next.z_out   = val[2];
    result_next.w_zero  = !sd.rotate && sd.wz;
    result_next.clipped = sd.rotate ? sd.rot_clip : clip;
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= v_s[DIV_STEPS];
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

`ifndef ASSERT_OFF
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LAT))
    else $error("result word without matching command");

  a_wzero: assert property (@(posedge clk) disable iff (rst)
    (done && result.w_zero) |-> (!result.clipped && result.x_out == '0 &&
                                 result.y_out == '0 && result.z_out == '0))
    else $error("zero w word carries data or clip");

  a_busy: assert property (@(posedge clk)
    !rst |-> !busy)
    else $error("busy outside reset");
`endif

endmodule
